// ===== sv/byte_deque_with_search_macros.svh =====
// Assertion macros used by the checker file of the byte deque.
`ifndef BYTE_DEQUE_WITH_SEARCH_MACROS_SVH
`define BYTE_DEQUE_WITH_SEARCH_MACROS_SVH

// Clocked assertion that is ignored while reset is held.
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/bdq_pkg.sv =====
// Package with sizes, request and status codes, and control types of the byte deque.
`default_nettype none

package bdq_pkg;

    // Ring size and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of the stream channels.
    localparam int REQ_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int FILL_W      = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_start;
        logic done;
        logic out_valid;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== sv/bdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/bdq_ctrl.sv =====
// Controller state machine that sequences requests and the search walk.
`default_nettype none

module bdq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    input  wire bdq_pkg::t_dp_sts i_sts,
    output logic                 o_in_ready,
    output bdq_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_ready;

    // A request is taken when idle and the result register is free or drains now.
    assign w_ready = (r_state == S_IDLE) && (!i_sts.out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid && w_ready;
                if (o_cmd.accept && i_sts.search_start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = w_ready;

endmodule

`default_nettype wire

// ===== sv/bdq_dp.sv =====
// Datapath: ring pointers, entry memory, search compare and result register.
`default_nettype none

module bdq_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bdq_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [bdq_pkg::BYTE_W-1:0]      i_item_byte,
    input  wire logic                            i_out_ready,
    input  wire bdq_pkg::t_dp_cmd                i_cmd,
    output bdq_pkg::t_dp_sts                     o_sts,
    output logic                                 o_out_valid,
    output logic      [bdq_pkg::STATUS_W-1:0]    o_status,
    output logic      [bdq_pkg::POS_W-1:0]       o_match_position,
    output logic      [bdq_pkg::FILL_W-1:0]      o_fill_count
);

    localparam int PW = bdq_pkg::PTR_W;
    localparam int CW = bdq_pkg::CNT_W;

    // Ring state.
    logic [PW-1:0] r_first;
    logic [PW-1:0] n_first;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;

    // Search walk.
    logic [bdq_pkg::BYTE_W-1:0] r_key;
    logic [PW-1:0]              r_rd_addr;
    logic [CW-1:0]              r_rd_cnt;
    logic                       r_cmp_vld;
    logic [PW-1:0]              r_cmp_pos;

    // Result register.
    logic                         r_out_valid;
    logic [bdq_pkg::STATUS_W-1:0] r_status;
    logic [bdq_pkg::STATUS_W-1:0] n_status;
    logic [PW-1:0]                r_pos;
    logic [PW-1:0]                n_pos;
    logic [CW-1:0]                r_cnt;
    logic                         w_load;

    // Memory port signals.
    logic                       w_wr_en;
    logic [PW-1:0]              w_wr_addr;
    logic                       w_rd_en;
    logic [bdq_pkg::BYTE_W-1:0] w_rd_data;

    logic          w_full;
    logic          w_empty;
    logic [PW-1:0] w_first_dec;
    logic [PW-1:0] w_first_inc;
    logic [PW:0]   w_back_sum;
    logic [PW-1:0] w_back_slot;
    logic [PW-1:0] w_rd_addr_inc;
    logic          w_hit;
    logic          w_last;

    assign w_full  = (r_fill == CW'(bdq_pkg::DEPTH));
    assign w_empty = (r_fill == '0);

    // Ring index arithmetic, wrapping at the ring size.
    assign w_first_dec   = (r_first == '0) ? PW'(bdq_pkg::DEPTH - 1) : r_first - PW'(1);
    assign w_first_inc   = (r_first == PW'(bdq_pkg::DEPTH - 1)) ? '0 : r_first + PW'(1);
    assign w_rd_addr_inc = (r_rd_addr == PW'(bdq_pkg::DEPTH - 1)) ? '0
                                                                  : r_rd_addr + PW'(1);
    assign w_back_sum    = {1'b0, r_first} + (PW + 1)'(r_fill);
    assign w_back_slot   = (w_back_sum >= (PW + 1)'(bdq_pkg::DEPTH))
                         ? PW'(w_back_sum - (PW + 1)'(bdq_pkg::DEPTH))
                         : w_back_sum[PW-1:0];

    // Compare of the entry that the memory returned this cycle.
    assign w_hit  = r_cmp_vld && (w_rd_data == r_key);
    assign w_last = r_cmp_vld && ((CW'(r_cmp_pos) + CW'(1)) == r_fill);

    // Immediate requests update the ring and build the result in the accept cycle.
    always_comb begin
        n_first   = r_first;
        n_fill    = r_fill;
        n_status  = bdq_pkg::ST_OK;
        n_pos     = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = w_back_slot;
        w_load    = 1'b0;
        if (i_cmd.accept) begin
            w_load = 1'b1;
            case (i_req_type)
                bdq_pkg::REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = bdq_pkg::ST_FULL;
                    end else begin
                        n_first   = w_first_dec;
                        n_fill    = r_fill + CW'(1);
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_first_dec;
                    end
                end
                bdq_pkg::REQ_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = bdq_pkg::ST_FULL;
                    end else begin
                        n_fill  = r_fill + CW'(1);
                        w_wr_en = 1'b1;
                    end
                end
                bdq_pkg::REQ_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = bdq_pkg::ST_EMPTY;
                    end else begin
                        n_first = w_first_inc;
                        n_fill  = r_fill - CW'(1);
                    end
                end
                bdq_pkg::REQ_POP_BACK: begin
                    if (w_empty) begin
                        n_status = bdq_pkg::ST_EMPTY;
                    end else begin
                        n_fill = r_fill - CW'(1);
                    end
                end
                bdq_pkg::REQ_SEARCH: begin
                    if (w_empty) begin
                        n_status = bdq_pkg::ST_EMPTY;
                    end else begin
                        w_load = 1'b0;
                    end
                end
                default: begin
                    n_status = bdq_pkg::ST_OK;
                end
            endcase
        end else if (i_cmd.finish) begin
            w_load   = 1'b1;
            n_status = w_hit ? bdq_pkg::ST_OK : bdq_pkg::ST_NOT_FOUND;
            n_pos    = w_hit ? r_cmp_pos : '0;
        end
    end

    // One entry is read per cycle while the walk has entries left.
    assign w_rd_en = i_cmd.step && (r_rd_cnt < r_fill);

    // Ring state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_first <= n_first;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_cmp_vld <= w_rd_en;
            end
        end
    end

    // Search walk counters and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= i_item_byte;
            r_rd_addr <= r_first;
            r_rd_cnt  <= '0;
        end else if (w_rd_en) begin
            r_rd_addr <= w_rd_addr_inc;
            r_rd_cnt  <= r_rd_cnt + CW'(1);
            r_cmp_pos <= r_rd_cnt[PW-1:0];
        end
        if (w_load) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_cnt    <= n_fill;
        end
    end

    bdq_ram #(
        .WIDTH(bdq_pkg::BYTE_W),
        .DEPTH(bdq_pkg::DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(i_item_byte),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign o_sts.search_start = (i_req_type == bdq_pkg::REQ_SEARCH) && !w_empty;
    assign o_sts.done         = w_hit || w_last;
    assign o_sts.out_valid    = r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_match_position = bdq_pkg::POS_W'(r_pos);
    assign o_fill_count     = bdq_pkg::FILL_W'(r_cnt);

endmodule

`default_nettype wire

// ===== sv/byte_deque_with_search.sv =====
// Push, pop, a result in the cycle after the beat is accepted; one request every cycle
// when the result side keeps up. Search walks the memory one entry per cycle through
// its single read port, compares each entry read with the key, and loads the result on
// a hit or after the last entry; no new request is taken until it ends.
// Synchronous active-low reset empties the deque and drops any pending result; entry
// contents stay undefined until written.
// Top level of the byte deque with search.
`default_nettype none

module byte_deque_with_search (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // item_byte [7:0]
    input  wire logic [bdq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type [2:0]
    input  wire logic [bdq_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status [1:0], match_position [5:2], fill_count [10:6], zero [15:11]
    output logic      [bdq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    bdq_pkg::t_dp_cmd                w_cmd;
    bdq_pkg::t_dp_sts                w_sts;
    logic [bdq_pkg::STATUS_W-1:0]    w_status;
    logic [bdq_pkg::POS_W-1:0]       w_pos;
    logic [bdq_pkg::FILL_W-1:0]      w_fill;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    bdq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (s_axis_tuser),
        .i_item_byte     (s_axis_tdata),
        .i_out_ready     (m_axis_tready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (w_status),
        .o_match_position(w_pos),
        .o_fill_count    (w_fill)
    );

    // Result beat packing, lowest field first.
    assign m_axis_tdata = {
        (bdq_pkg::OUT_TDATA_W - bdq_pkg::STATUS_W - bdq_pkg::POS_W - bdq_pkg::FILL_W)'(0),
        w_fill, w_pos, w_status
    };

endmodule

`default_nettype wire

// ===== sv/bdq_checker.sv =====
// Port-level checker for the byte deque, bound to the top level.
`default_nettype none

`include "byte_deque_with_search_macros.svh"

module bdq_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [bdq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [bdq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [bdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [bdq_pkg::STATUS_W-1:0] w_status;
    logic [bdq_pkg::POS_W-1:0]    w_pos;
    logic [bdq_pkg::FILL_W-1:0]   w_fill;

    assign w_status = m_axis_tdata[1:0];
    assign w_pos    = m_axis_tdata[5:2];
    assign w_fill   = m_axis_tdata[10:6];

    // A result beat is held until it is taken.
    `BDQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped before taken")

    // Reset leaves no result pending.
    `BDQ_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // A dropped push is only reported on a full ring.
    `BDQ_ASSERT(a_full_count, m_axis_tvalid && (w_status == bdq_pkg::ST_FULL) |-> (w_fill == bdq_pkg::FILL_W'(bdq_pkg::DEPTH)), "full status with ring not full")

    // An empty status comes with an empty ring.
    `BDQ_ASSERT(a_empty_count, m_axis_tvalid && (w_status == bdq_pkg::ST_EMPTY) |-> (w_fill == '0), "empty status with entries held")

    // A nonzero position only comes with a successful search.
    `BDQ_ASSERT(a_pos_ok, m_axis_tvalid && (w_pos != '0) |-> (w_status == bdq_pkg::ST_OK), "position reported without a match")

endmodule

bind byte_deque_with_search bdq_checker u_bdq_checker (.*);

`default_nettype wire
